// ===== hw/rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: action and status codes.
// No dependencies; imported by rational_arithmetic_unit.
`default_nettype none

package rau_pkg;

    typedef enum logic [2:0] {
        ACT_REDUCE  = 3'd0,
        ACT_ADD     = 3'd1,
        ACT_SUB     = 3'd2,
        ACT_MUL     = 3'd3,
        ACT_DIV     = 3'd4,
        ACT_EQUAL   = 3'd5,
        ACT_GREATER = 3'd6,
        ACT_LESS    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    localparam int FIELD_W   = 32;
    localparam int DEN_W     = 31;
    localparam int IN_DATA_W = 136;
    localparam int OUT_DATA_W = 72;

endpackage

`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: sequencer around one shared multiplier and
// one shared add/subtract unit. Depends on rau_pkg.
`default_nettype none

// Each input item holds an action and two fractions; one result item follows.
// An item is taken only when the unit is idle and then runs in order: the
// multiplier products an*bd, bn*ad, ad*bd (ad*bn for a divide) and an*bn, a
// combine step, a binary GCD (one shift or subtract per cycle) and two
// restoring divisions by the GCD (2*WIDTH quotient bits each), all on the same
// subtractor. Compares and errors skip the GCD and divisions. The result
// sits in an output register, and the next item is taken while it waits.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // action[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // res_num[31:0], res_den[62:32], truth[63], status[65:64], zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int PW = 2 * WIDTH;
    localparam int AW = PW + 2;
    localparam int KW = $clog2(PW);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_COMB, S_GCD, S_DIVN, S_DIVD, S_OUT
    } state_t;

    function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] f);
        return f[WIDTH-1] ? (~f + 1'b1) : f;
    endfunction

    state_t            state_reg;
    action_t           action_reg;
    logic [WIDTH-1:0]  an_reg, ad_reg, bn_reg, bd_reg;
    logic              an_neg_reg, bn_neg_reg;
    logic [1:0]        step_reg;
    logic [PW-1:0]     p0_reg, p1_reg, pd_reg, pm_reg;
    logic              neg_reg;
    logic [PW-1:0]     u_reg, v_reg, g_reg;
    logic [KW-1:0]     k_reg;
    logic [PW-1:0]     rem_reg, quo_reg, den_keep_reg, nq_reg, dq_reg;
    logic [KW-1:0]     cnt_reg;
    logic              frac_reg, truth_reg;
    status_t           status_reg;

    // Input field decode
    logic [FIELD_W-1:0] in_an, in_ad, in_bn, in_bd;
    logic [WIDTH-1:0]   fa_n, fa_d, fb_n, fb_d;
    assign in_an = s_axis_tdata[34:3];
    assign in_ad = s_axis_tdata[66:35];
    assign in_bn = s_axis_tdata[98:67];
    assign in_bd = s_axis_tdata[130:99];
    assign fa_n  = in_an[WIDTH-1:0];
    assign fa_d  = in_ad[WIDTH-1:0];
    assign fb_n  = in_bn[WIDTH-1:0];
    assign fb_d  = in_bd[WIDTH-1:0];

    assign s_axis_tready = (state_reg == S_IDLE);

    // Shared multiplier
    logic [WIDTH-1:0] mul_a, mul_b;
    logic [PW-1:0]    mul_p;
    always_comb
    begin
        case (step_reg)
            2'd0:    begin mul_a = an_reg; mul_b = bd_reg; end
            2'd1:    begin mul_a = bn_reg; mul_b = ad_reg; end
            2'd2:    begin mul_a = ad_reg; mul_b = (action_reg == ACT_DIV) ? bn_reg : bd_reg; end
            default: begin mul_a = an_reg; mul_b = bn_reg; end
        endcase
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // Shared add/subtract unit
    logic          is_sub_act, same_sign, alu_sub;
    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          borrow, alu_zero;
    logic [PW-1:0] diff, neg_diff;
    logic [PW:0]   trial;

    assign is_sub_act = (action_reg == ACT_SUB);
    assign same_sign  = (an_neg_reg == (bn_neg_reg ^ is_sub_act));
    assign trial      = {rem_reg, quo_reg[PW-1]};

    always_comb
    begin
        alu_a   = AW'(p0_reg);
        alu_b   = AW'(p1_reg);
        alu_sub = 1'b1;
        case (state_reg)
            S_COMB:
            begin
                alu_sub = !((action_reg == ACT_ADD || action_reg == ACT_SUB) && same_sign);
            end
            S_GCD:
            begin
                alu_a = AW'(u_reg);
                alu_b = AW'(v_reg);
            end
            S_DIVN, S_DIVD:
            begin
                alu_a = AW'(trial);
                alu_b = AW'(g_reg);
            end
            default: ;
        endcase
    end

    assign alu_res  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign borrow   = alu_res[AW-1];
    assign alu_zero = (alu_res == '0);
    assign diff     = alu_res[PW-1:0];
    assign neg_diff = ~diff + 1'b1;

    // Result formatting
    logic             ovf;
    logic [WIDTH-1:0] out_num;
    assign ovf     = (nq_reg[PW-1:WIDTH-1] != '0) || (dq_reg[PW-1:WIDTH-1] != '0);
    assign out_num = (neg_reg && nq_reg != '0) ? (~nq_reg[WIDTH-1:0] + 1'b1)
                                               : nq_reg[WIDTH-1:0];

    logic [OUT_DATA_W-1:0] out_data;
    always_comb
    begin
        out_data = '0;
        if (!frac_reg)
        begin
            out_data[63]    = truth_reg;
            out_data[65:64] = status_reg;
        end
        else if (ovf)
            out_data[65:64] = ST_OVERFLOW;
        else
        begin
            out_data[31:0]  = FIELD_W'(signed'(out_num));
            out_data[62:32] = DEN_W'(dq_reg[WIDTH-2:0]);
        end
    end

    logic cmp_eq, cmp_gt, cmp_lt;
    assign cmp_eq = (an_neg_reg == bn_neg_reg) && alu_zero;
    assign cmp_gt = (an_neg_reg != bn_neg_reg) ? bn_neg_reg
                  : (an_neg_reg ? (borrow && !alu_zero) : (!borrow && !alu_zero));
    assign cmp_lt = !cmp_eq && !cmp_gt;

    logic [PW-1:0] comb_num, comb_den;
    logic          comb_neg;
    always_comb
    begin
        comb_den = pd_reg;
        comb_neg = an_neg_reg ^ bn_neg_reg;
        comb_num = pm_reg;
        case (action_reg)
            ACT_REDUCE:
            begin
                comb_num = PW'(an_reg);
                comb_den = PW'(ad_reg);
                comb_neg = an_neg_reg;
            end
            ACT_ADD, ACT_SUB:
            begin
                if (same_sign)
                begin
                    comb_num = diff;
                    comb_neg = an_neg_reg;
                end
                else if (borrow)
                begin
                    comb_num = neg_diff;
                    comb_neg = !an_neg_reg;
                end
                else
                begin
                    comb_num = diff;
                    comb_neg = an_neg_reg;
                end
            end
            ACT_DIV:
            begin
                comb_num = p0_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_axis_tvalid <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (state_reg == S_OUT && (!m_axis_tvalid || m_axis_tready))
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        action_reg <= action_t'(s_axis_tdata[2:0]);
                        an_reg     <= mag_of(fa_n);
                        ad_reg     <= mag_of(fa_d);
                        bn_reg     <= mag_of(fb_n);
                        bd_reg     <= mag_of(fb_d);
                        an_neg_reg <= (fa_n != '0) && (fa_n[WIDTH-1] ^ fa_d[WIDTH-1]);
                        bn_neg_reg <= (fb_n != '0) && (fb_n[WIDTH-1] ^ fb_d[WIDTH-1]);
                        step_reg   <= '0;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    case (step_reg)
                        2'd0:    p0_reg <= mul_p;
                        2'd1:    p1_reg <= mul_p;
                        2'd2:    pd_reg <= mul_p;
                        default: pm_reg <= mul_p;
                    endcase
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                        state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    neg_reg <= comb_neg;
                    if (ad_reg == '0 || (action_reg != ACT_REDUCE && bd_reg == '0))
                    begin
                        frac_reg   <= 1'b0;
                        truth_reg  <= 1'b0;
                        status_reg <= ST_ZERO_DEN;
                        state_reg  <= S_OUT;
                    end
                    else if (action_reg == ACT_EQUAL || action_reg == ACT_GREATER
                             || action_reg == ACT_LESS)
                    begin
                        frac_reg   <= 1'b0;
                        truth_reg  <= (action_reg == ACT_EQUAL) ? cmp_eq
                                    : (action_reg == ACT_GREATER) ? cmp_gt : cmp_lt;
                        status_reg <= ST_OK;
                        state_reg  <= S_OUT;
                    end
                    else if (action_reg == ACT_DIV && bn_reg == '0)
                    begin
                        frac_reg   <= 1'b0;
                        truth_reg  <= 1'b0;
                        status_reg <= ST_DIV_ZERO;
                        state_reg  <= S_OUT;
                    end
                    else if (comb_num == '0)
                    begin
                        frac_reg   <= 1'b1;
                        truth_reg  <= 1'b0;
                        status_reg <= ST_OK;
                        nq_reg     <= '0;
                        dq_reg     <= PW'(1);
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        frac_reg     <= 1'b1;
                        truth_reg    <= 1'b0;
                        status_reg   <= ST_OK;
                        u_reg        <= comb_num;
                        v_reg        <= comb_den;
                        quo_reg      <= comb_num;
                        den_keep_reg <= comb_den;
                        k_reg        <= '0;
                        state_reg    <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    if (alu_zero)
                    begin
                        g_reg     <= u_reg << k_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIVN;
                    end
                    else if (!u_reg[0] && !v_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!u_reg[0])
                        u_reg <= u_reg >> 1;
                    else if (!v_reg[0])
                        v_reg <= v_reg >> 1;
                    else if (borrow)
                        v_reg <= neg_diff;
                    else
                        u_reg <= diff;
                end
                S_DIVN, S_DIVD:
                begin
                    // one quotient bit per cycle
                    if (cnt_reg == KW'(PW - 1))
                    begin
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        if (state_reg == S_DIVN)
                        begin
                            nq_reg    <= {quo_reg[PW-2:0], !borrow};
                            quo_reg   <= den_keep_reg;
                            state_reg <= S_DIVD;
                        end
                        else
                        begin
                            dq_reg    <= {quo_reg[PW-2:0], !borrow};
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        rem_reg <= borrow ? trial[PW-1:0] : diff;
                        quo_reg <= {quo_reg[PW-2:0], !borrow};
                    end
                end
                S_OUT:
                begin
                    if (!m_axis_tvalid || m_axis_tready)
                    begin
                        m_axis_tdata <= out_data;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_MUL))
        else $error("accepted item did not start the multiply sequence");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GCD) |-> (u_reg != '0 && v_reg != '0))
        else $error("GCD operand became zero");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[65:64] != ST_OK)
            |-> (m_axis_tdata[63:0] == '0))
        else $error("error result carries non-zero fields");

    a_truth_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[63]) |-> (m_axis_tdata[62:0] == '0))
        else $error("truth set on an arithmetic result");
`endif

endmodule

`default_nettype wire
